[rtl/rrtr_pkg.sv]
package rrtr_pkg;

    // Fixed arithmetic constants
    localparam logic [15:0] MS_PER_MIN = 16'd60000;
    localparam logic [23:0] RATE_NUM   = 24'd15360000;

    // Register reset values
    localparam logic [9:0]  GRID_STEP_RST = 10'd250;
    localparam logic [7:0]  MIN_BPM_RST   = 8'd40;
    localparam logic [7:0]  MAX_BPM_RST   = 8'd200;
    localparam logic [15:0] FALLBACK_RST  = 16'd15360;

    // Default sizes
    localparam int MAX_RUN_DEF    = 64;
    localparam int CMDQ_DEPTH_DEF = 2;
    localparam int OUTQ_DEPTH_DEF = 2;

    // Shared divider: dividend and divisor widths
    localparam int DIV_N = 48;
    localparam int DIV_D = 32;

    // Configuration port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    typedef enum logic [1:0] {
        REG_GRID_STEP = 2'd0,
        REG_MIN_BPM   = 2'd1,
        REG_MAX_BPM   = 2'd2,
        REG_FALLBACK  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [9:0]  grid_step_ms;
        logic [7:0]  min_bpm;
        logic [7:0]  max_bpm;
        logic [15:0] fallback_bpm_q8;
    } t_cfg;

    // Classified beat handed from front to back
    typedef struct packed {
        logic        first;
        logic        in_band;
        logic [15:0] rr;
        logic [31:0] t;
    } t_cmd;

    typedef struct packed {
        logic [31:0] sample_time_ms;
        logic [15:0] rate_q8;
        logic        on_beat;
        logic        gap_restart;
        logic        last_of_run;
    } t_result;

    typedef struct packed {
        logic             start;
        logic [DIV_N-1:0] dividend;
        logic [DIV_D-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_N-1:0] quot;
        logic [DIV_D-1:0] rem;
    } t_div_rsp;

endpackage

[rtl/rr_tachogram_resampler_top.sv]
// Channel   Handshake                  Payload
// -------   ------------------------   ---------------------------------------------
// config    psel, penable, pwrite      paddr, pwdata in; prdata out; pready high
// beat in   push in, full out          i_rr_ms, i_first_beat
// sample    empty out, pop in          o_sample_time_ms, o_rate_q8, o_on_beat,
//                                      o_gap_restart, o_last_of_run
//
// The front takes one beat per cycle while its two-entry beat queue has room.
// The back runs each kept beat through one shared divider up to four times (rate, grid
// count, interpolation start and slope; fewer for a first beat, a beat with no grid point
// or a span past MAX_RUN), then emits one sample per cycle while the result queue has
// room; dropped beats cost the back nothing.
// Reset is synchronous and clears all control state; config returns to defaults.
// A full result queue stalls emission only; the beat queue fills on its own.
module rr_tachogram_resampler_top #(
    parameter int MAX_RUN    = rrtr_pkg::MAX_RUN_DEF,
    parameter int CMDQ_DEPTH = rrtr_pkg::CMDQ_DEPTH_DEF,
    parameter int OUTQ_DEPTH = rrtr_pkg::OUTQ_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rrtr_pkg::APB_AW-1:0] paddr,
    input  logic [rrtr_pkg::APB_DW-1:0] pwdata,
    output logic [rrtr_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    input  logic                        push,
    output logic                        full,
    input  logic [15:0]                 i_rr_ms,
    input  logic                        i_first_beat,
    output logic                        empty,
    input  logic                        pop,
    output logic [31:0]                 o_sample_time_ms,
    output logic [15:0]                 o_rate_q8,
    output logic                        o_on_beat,
    output logic                        o_gap_restart,
    output logic                        o_last_of_run
);

    localparam int CMD_W = $bits(rrtr_pkg::t_cmd);
    localparam int RES_W = $bits(rrtr_pkg::t_result);

    rrtr_pkg::t_cfg     r_cfg, n_cfg;
    rrtr_pkg::t_reg_idx w_idx;
    logic               w_wr;

    logic               w_cmdq_full, w_cmdq_empty, w_cmd_push, w_cmd_pop;
    rrtr_pkg::t_cmd     w_cmd_in, w_cmd_out;
    logic               w_outq_full, w_res_push;
    rrtr_pkg::t_result  w_res_in, w_res_out;
    rrtr_pkg::t_div_req w_div_req;
    rrtr_pkg::t_div_rsp w_div_rsp;

    // Register file
    assign pready = 1'b1;
    assign w_idx  = rrtr_pkg::t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                rrtr_pkg::REG_GRID_STEP: n_cfg.grid_step_ms    = pwdata[9:0];
                rrtr_pkg::REG_MIN_BPM:   n_cfg.min_bpm         = pwdata[7:0];
                rrtr_pkg::REG_MAX_BPM:   n_cfg.max_bpm         = pwdata[7:0];
                rrtr_pkg::REG_FALLBACK:  n_cfg.fallback_bpm_q8 = pwdata[15:0];
                default:                 n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            rrtr_pkg::REG_GRID_STEP: prdata = {22'd0, r_cfg.grid_step_ms};
            rrtr_pkg::REG_MIN_BPM:   prdata = {24'd0, r_cfg.min_bpm};
            rrtr_pkg::REG_MAX_BPM:   prdata = {24'd0, r_cfg.max_bpm};
            rrtr_pkg::REG_FALLBACK:  prdata = {16'd0, r_cfg.fallback_bpm_q8};
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_step_ms    <= rrtr_pkg::GRID_STEP_RST;
            r_cfg.min_bpm         <= rrtr_pkg::MIN_BPM_RST;
            r_cfg.max_bpm         <= rrtr_pkg::MAX_BPM_RST;
            r_cfg.fallback_bpm_q8 <= rrtr_pkg::FALLBACK_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    rrtr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_push       (push),
        .i_rr_ms      (i_rr_ms),
        .i_first_beat (i_first_beat),
        .i_q_full     (w_cmdq_full),
        .o_full       (full),
        .o_cmd_push   (w_cmd_push),
        .o_cmd        (w_cmd_in)
    );

    rrtr_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_data  (w_cmd_in),
        .o_full  (w_cmdq_full),
        .i_pop   (w_cmd_pop),
        .o_data  (w_cmd_out),
        .o_empty (w_cmdq_empty)
    );

    rrtr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    rrtr_back #(
        .MAX_RUN (MAX_RUN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (!w_cmdq_empty),
        .i_cmd       (w_cmd_out),
        .o_cmd_pop   (w_cmd_pop),
        .o_div_req   (w_div_req),
        .i_div_rsp   (w_div_rsp),
        .i_out_full  (w_outq_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res_in)
    );

    rrtr_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_outq_full),
        .i_pop   (pop),
        .o_data  (w_res_out),
        .o_empty (empty)
    );

    assign o_sample_time_ms = w_res_out.sample_time_ms;
    assign o_rate_q8        = w_res_out.rate_q8;
    assign o_on_beat        = w_res_out.on_beat;
    assign o_gap_restart    = w_res_out.gap_restart;
    assign o_last_of_run    = w_res_out.last_of_run;

endmodule

[rtl/rrtr_fifo.sv]
module rrtr_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_data    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // Advance pointers and count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + CW'(1);
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the item
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[rtl/rrtr_front.sv]
module rrtr_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rrtr_pkg::t_cfg      i_cfg,
    input  logic                i_push,
    input  logic [15:0]         i_rr_ms,
    input  logic                i_first_beat,
    input  logic                i_q_full,
    output logic                o_full,
    output logic                o_cmd_push,
    output rrtr_pkg::t_cmd      o_cmd
);

    logic        r_record_open, n_record_open;
    logic [31:0] r_beat_clock, n_beat_clock;
    logic        w_accept;
    logic        w_in_band;
    logic [23:0] w_min_prod, w_max_prod;
    logic [32:0] w_clock_sum;
    logic [31:0] w_clock_sat;

    assign o_full   = i_q_full;
    assign w_accept = i_push && !i_q_full;

    // Classify the beat against the bpm band
    assign w_min_prod = 24'(i_cfg.min_bpm) * 24'(i_rr_ms);
    assign w_max_prod = 24'(i_cfg.max_bpm) * 24'(i_rr_ms);
    assign w_in_band  = (i_rr_ms != '0)
                      && (w_min_prod <= 24'(rrtr_pkg::MS_PER_MIN))
                      && (w_max_prod >= 24'(rrtr_pkg::MS_PER_MIN));

    // Saturating beat time
    assign w_clock_sum = {1'b0, r_beat_clock} + 33'(i_rr_ms);
    assign w_clock_sat = w_clock_sum[32] ? '1 : w_clock_sum[31:0];

    always_comb begin
        n_record_open = r_record_open;
        n_beat_clock  = r_beat_clock;
        o_cmd_push    = 1'b0;
        o_cmd.first   = i_first_beat;
        o_cmd.in_band = w_in_band;
        o_cmd.rr      = i_rr_ms;
        o_cmd.t       = w_clock_sat;
        priority if (w_accept && i_first_beat) begin
            n_record_open = 1'b1;
            n_beat_clock  = '0;
            o_cmd.t       = '0;
            o_cmd_push    = 1'b1;
        end else if (w_accept && r_record_open) begin
            // drop out-of-band beats, but keep the time they add
            n_beat_clock = w_clock_sat;
            o_cmd_push   = w_in_band;
        end else begin
            o_cmd_push = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_record_open <= 1'b0;
            r_beat_clock  <= '0;
        end else begin
            r_record_open <= n_record_open;
            r_beat_clock  <= n_beat_clock;
        end
    end

endmodule

[rtl/rrtr_div.sv]
module rrtr_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rrtr_pkg::t_div_req   i_req,
    output rrtr_pkg::t_div_rsp   o_rsp
);

    localparam int N  = rrtr_pkg::DIV_N;
    localparam int D  = rrtr_pkg::DIV_D;
    localparam int CW = $clog2(N + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [N-1:0]  r_quot, n_quot;
    logic [D-1:0]  r_rem, n_rem;
    logic [D-1:0]  r_divisor, n_divisor;
    logic [D:0]    w_shift;
    logic [D+1:0]  w_diff;
    logic          w_ge;

    // One quotient bit per cycle, restoring
    assign w_shift = {r_rem, r_quot[N-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_divisor};
    assign w_ge    = !w_diff[D+1];

    always_comb begin
        n_busy    = r_busy;
        n_done    = 1'b0;
        n_cnt     = r_cnt;
        n_quot    = r_quot;
        n_rem     = r_rem;
        n_divisor = r_divisor;
        priority if (i_req.start) begin
            n_busy    = 1'b1;
            n_cnt     = CW'(N);
            n_quot    = i_req.dividend;
            n_rem     = '0;
            n_divisor = i_req.divisor;
        end else if (r_busy) begin
            n_quot = {r_quot[N-2:0], w_ge};
            n_rem  = w_ge ? w_diff[D-1:0] : w_shift[D-1:0];
            n_cnt  = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot    <= n_quot;
        r_rem     <= n_rem;
        r_divisor <= n_divisor;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

endmodule

[rtl/rrtr_back.sv]
module rrtr_back #(
    parameter int MAX_RUN = rrtr_pkg::MAX_RUN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rrtr_pkg::t_cfg       i_cfg,
    input  logic                 i_cmd_valid,
    input  rrtr_pkg::t_cmd       i_cmd,
    output logic                 o_cmd_pop,
    output rrtr_pkg::t_div_req   o_div_req,
    input  rrtr_pkg::t_div_rsp   i_div_rsp,
    input  logic                 i_out_full,
    output logic                 o_res_push,
    output rrtr_pkg::t_result    o_res
);

    localparam int KW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
    localparam int N  = rrtr_pkg::DIV_N;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_RATE  = 10'b0000000010,
        S_CNT   = 10'b0000000100,
        S_MUL0  = 10'b0000001000,
        S_DIV0  = 10'b0000010000,
        S_DIV1  = 10'b0000100000,
        S_EMIT  = 10'b0001000000,
        S_FIRST = 10'b0010000000,
        S_GAP   = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } t_state;

    // Floor quotient and non-negative remainder
    typedef struct packed {
        logic signed [17:0] q;
        logic [31:0]        r;
    } t_qr;

    function automatic t_qr floor_qr(input logic neg, input logic [17:0] q,
                                     input logic [31:0] rem, input logic [31:0] span);
        t_qr res;
        if (!neg) begin
            res.q = q;
            res.r = rem;
        end else if (rem != '0) begin
            res.q = ~q;
            res.r = span - rem;
        end else begin
            res.q = ~q + 18'd1;
            res.r = '0;
        end
        return res;
    endfunction

    t_state             r_state, n_state;
    logic [31:0]        r_anchor_time, n_anchor_time;
    logic [15:0]        r_anchor_rate, n_anchor_rate;
    logic [31:0]        r_next_grid, n_next_grid;
    rrtr_pkg::t_cmd     r_cmd, n_cmd;
    logic [15:0]        r_yb, n_yb;
    logic [31:0]        r_g, n_g;
    logic [31:0]        r_next_after, n_next_after;
    logic [KW-1:0]      r_k, n_k;
    logic [KW-1:0]      r_last_k, n_last_k;
    logic [31:0]        r_span, n_span;
    logic [15:0]        r_mag, n_mag;
    logic               r_neg, n_neg;
    logic signed [17:0] r_q, n_q;
    logic [31:0]        r_r, n_r;
    logic signed [17:0] r_qs, n_qs;
    logic [31:0]        r_rs, n_rs;
    logic               r_div_start, n_div_start;
    logic [N-1:0]       r_dividend, n_dividend;
    logic [31:0]        r_divisor, n_divisor;

    logic [9:0]         w_step;
    logic [31:0]        w_gl;
    logic [32:0]        w_after_sum;
    logic               w_long;
    logic signed [18:0] w_rate_sum;
    logic [15:0]        w_interp;
    logic [32:0]        w_rsum;
    logic               w_rwrap;
    logic               w_last;
    t_qr                w_qr;

    assign w_step = (i_cfg.grid_step_ms == '0) ? 10'd1 : i_cfg.grid_step_ms;

    // Last grid point not beyond the beat, and the grid point after it
    assign w_gl        = r_cmd.t - {22'd0, i_div_rsp.rem[9:0]};
    assign w_after_sum = {1'b0, w_gl} + 33'(w_step);
    assign w_long      = (i_div_rsp.quot >= N'(MAX_RUN));

    // Interpolated rate, clamped to the Q8.8 range
    assign w_rate_sum = $signed({3'b000, r_anchor_rate}) + {r_q[17], r_q};
    always_comb begin
        priority if (w_rate_sum < 0) begin
            w_interp = '0;
        end else if (w_rate_sum > 19'sd65535) begin
            w_interp = '1;
        end else begin
            w_interp = w_rate_sum[15:0];
        end
    end

    // Remainder step toward the next grid point
    assign w_rsum  = {1'b0, r_r} + {1'b0, r_rs};
    assign w_rwrap = (w_rsum >= {1'b0, r_span});
    assign w_last  = (r_k == r_last_k);
    assign w_qr    = floor_qr(r_neg, i_div_rsp.quot[17:0], i_div_rsp.rem, r_span);

    always_comb begin
        n_state       = r_state;
        n_anchor_time = r_anchor_time;
        n_anchor_rate = r_anchor_rate;
        n_next_grid   = r_next_grid;
        n_cmd         = r_cmd;
        n_yb          = r_yb;
        n_g           = r_g;
        n_next_after  = r_next_after;
        n_k           = r_k;
        n_last_k      = r_last_k;
        n_span        = r_span;
        n_mag         = r_mag;
        n_neg         = r_neg;
        n_q           = r_q;
        n_r           = r_r;
        n_qs          = r_qs;
        n_rs          = r_rs;
        n_div_start   = 1'b0;
        n_dividend    = r_dividend;
        n_divisor     = r_divisor;
        o_cmd_pop     = 1'b0;
        o_res_push    = 1'b0;
        o_res.sample_time_ms = r_g;
        o_res.rate_q8        = (r_g == r_cmd.t) ? r_yb : w_interp;
        o_res.on_beat        = (r_g == r_cmd.t);
        o_res.gap_restart    = 1'b0;
        o_res.last_of_run    = w_last;

        unique case (r_state)
            S_IDLE: begin
                // take the next classified beat
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    if (i_cmd.first && !i_cmd.in_band) begin
                        n_yb    = i_cfg.fallback_bpm_q8;
                        n_state = S_FIRST;
                    end else begin
                        n_div_start = 1'b1;
                        n_dividend  = N'(rrtr_pkg::RATE_NUM);
                        n_divisor   = 32'(i_cmd.rr);
                        n_state     = S_RATE;
                    end
                end
            end
            S_RATE: begin
                // beat rate ready; unless first or short of the next grid point, count the grid points it covers
                if (i_div_rsp.done) begin
                    n_yb = i_div_rsp.quot[15:0];
                    priority if (r_cmd.first) begin
                        n_state = S_FIRST;
                    end else if (r_next_grid > r_cmd.t) begin
                        n_anchor_time = r_cmd.t;
                        n_anchor_rate = i_div_rsp.quot[15:0];
                        n_state       = S_IDLE;
                    end else begin
                        n_div_start = 1'b1;
                        n_dividend  = N'(r_cmd.t - r_next_grid);
                        n_divisor   = 32'(w_step);
                        n_state     = S_CNT;
                    end
                end
            end
            S_CNT: begin
                if (i_div_rsp.done) begin
                    n_g          = w_long ? w_gl : r_next_grid;
                    n_next_after = w_after_sum[32] ? '1 : w_after_sum[31:0];
                    n_last_k     = i_div_rsp.quot[KW-1:0];
                    n_k          = '0;
                    n_span       = r_cmd.t - r_anchor_time;
                    n_neg        = (r_yb < r_anchor_rate);
                    n_mag        = (r_yb < r_anchor_rate) ? r_anchor_rate - r_yb
                                                          : r_yb - r_anchor_rate;
                    n_state      = w_long ? S_GAP : S_MUL0;
                end
            end
            S_MUL0: begin
                // rate delta times offset of the first grid point
                n_div_start = 1'b1;
                n_dividend  = N'(r_mag) * N'(r_next_grid - r_anchor_time);
                n_divisor   = r_span;
                n_state     = S_DIV0;
            end
            S_DIV0: begin
                if (i_div_rsp.done) begin
                    n_q         = w_qr.q;
                    n_r         = w_qr.r;
                    n_div_start = 1'b1;
                    n_dividend  = N'(r_mag) * N'(w_step);
                    n_divisor   = r_span;
                    n_state     = S_DIV1;
                end
            end
            S_DIV1: begin
                if (i_div_rsp.done) begin
                    n_qs    = w_qr.q;
                    n_rs    = w_qr.r;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // one grid point per cycle while the result queue has room
                if (!i_out_full) begin
                    o_res_push = 1'b1;
                    n_g        = r_g + 32'(w_step);
                    n_k        = r_k + KW'(1);
                    if (w_rwrap) begin
                        n_r = 32'(w_rsum - {1'b0, r_span});
                        n_q = r_q + r_qs + 18'sd1;
                    end else begin
                        n_r = w_rsum[31:0];
                        n_q = r_q + r_qs;
                    end
                    if (w_last) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_FIRST: begin
                o_res.sample_time_ms = '0;
                o_res.rate_q8        = r_yb;
                o_res.on_beat        = 1'b1;
                o_res.last_of_run    = 1'b1;
                if (!i_out_full) begin
                    o_res_push    = 1'b1;
                    n_anchor_time = '0;
                    n_anchor_rate = r_yb;
                    n_next_grid   = 32'(w_step);
                    n_state       = S_IDLE;
                end
            end
            S_GAP: begin
                // re-anchor at the last grid point with the beat's own rate
                o_res.rate_q8     = r_yb;
                o_res.gap_restart = 1'b1;
                o_res.last_of_run = 1'b1;
                if (!i_out_full) begin
                    o_res_push = 1'b1;
                    n_state    = S_DONE;
                end
            end
            S_DONE: begin
                n_anchor_time = r_cmd.t;
                n_anchor_rate = r_yb;
                n_next_grid   = r_next_after;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_anchor_time <= '0;
            r_anchor_rate <= '0;
            r_next_grid   <= '0;
            r_div_start   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_anchor_time <= n_anchor_time;
            r_anchor_rate <= n_anchor_rate;
            r_next_grid   <= n_next_grid;
            r_div_start   <= n_div_start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_yb         <= n_yb;
        r_g          <= n_g;
        r_next_after <= n_next_after;
        r_k          <= n_k;
        r_last_k     <= n_last_k;
        r_span       <= n_span;
        r_mag        <= n_mag;
        r_neg        <= n_neg;
        r_q          <= n_q;
        r_r          <= n_r;
        r_qs         <= n_qs;
        r_rs         <= n_rs;
        r_dividend   <= n_dividend;
        r_divisor    <= n_divisor;
    end

    assign o_div_req.start    = r_div_start;
    assign o_div_req.dividend = r_dividend;
    assign o_div_req.divisor  = r_divisor;

endmodule

[rtl/rrtr_checker.sv]
module rrtr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [31:0] o_sample_time_ms,
    input logic [15:0] o_rate_q8,
    input logic        o_on_beat,
    input logic        o_gap_restart,
    input logic        o_last_of_run
);

    // Nothing waits right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> empty)
        else $error("result queue not empty after reset");

    // A re-anchored sample always closes its beat's run
    a_gap_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_gap_restart) |-> o_last_of_run)
        else $error("gap sample not marked last of run");

    // Only the final sample of a run can sit on the beat
    a_on_beat_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_last_of_run) |-> !o_on_beat)
        else $error("on-beat sample before end of run");

    // A waiting item holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_sample_time_ms)
                              && $stable(o_rate_q8)))
        else $error("waiting result changed before pop");

endmodule

bind rr_tachogram_resampler_top rrtr_checker u_checker (.*);

[verif/rr_tachogram_resampler_top_tb.sv]
module rr_tachogram_resampler_top_tb;

    localparam int SPAN_LIMIT         = rrtr_pkg::MAX_RUN_DEF;
    localparam int SETTLE_CYCLES      = 1000;
    localparam int HOLD_CYCLES        = 3000;
    localparam int WATCHDOG_LIMIT     = 20000;
    localparam int RANDOM_PER_SETTING = 103;
    localparam logic [31:0] CLOCK_MAX = 32'hFFFF_FFFF;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [rrtr_pkg::APB_AW-1:0]   paddr;
    logic [rrtr_pkg::APB_DW-1:0]   pwdata;
    logic [rrtr_pkg::APB_DW-1:0]   prdata;
    logic                          pready;
    logic                          push;
    logic                          full;
    logic [15:0]                   i_rr_ms;
    logic                          i_first_beat;
    logic                          empty;
    logic                          pop;
    logic [31:0]                   o_sample_time_ms;
    logic [15:0]                   o_rate_q8;
    logic                          o_on_beat;
    logic                          o_gap_restart;
    logic                          o_last_of_run;

    // Predictor copy of the registers and the beat state
    logic [9:0]           cfg_step;
    logic [7:0]           cfg_min_bpm;
    logic [7:0]           cfg_max_bpm;
    logic [15:0]          cfg_fallback;
    logic [31:0]          beat_clock_ms;
    logic [31:0]          anchor_ms;
    logic [15:0]          anchor_rate;
    logic [31:0]          next_grid_ms;
    logic                 record_open;

    rrtr_pkg::t_result    pending_samples[$];

    int                   mismatches;
    int                   beats_accepted;
    int                   ignored_beats;
    int                   samples_checked;
    int                   restart_samples;
    int                   settings_used;
    int                   hold_rx_cycles;
    int                   quiet_cycles;

    rr_tachogram_resampler_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .push             (push),
        .full             (full),
        .i_rr_ms          (i_rr_ms),
        .i_first_beat     (i_first_beat),
        .empty            (empty),
        .pop              (pop),
        .o_sample_time_ms (o_sample_time_ms),
        .o_rate_q8        (o_rate_q8),
        .o_on_beat        (o_on_beat),
        .o_gap_restart    (o_gap_restart),
        .o_last_of_run    (o_last_of_run)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Band check done exactly on whole bpm
    function automatic logic beat_in_band(input logic [15:0] rr);
        int unsigned r;
        int unsigned lo_prod;
        int unsigned hi_prod;
        r = rr;
        lo_prod = cfg_min_bpm * r;
        hi_prod = cfg_max_bpm * r;
        return (r != 0) && (lo_prod <= rrtr_pkg::MS_PER_MIN)
            && (hi_prod >= rrtr_pkg::MS_PER_MIN);
    endfunction

    function automatic logic [15:0] beat_rate(input logic [15:0] rr);
        int unsigned q;
        q = rrtr_pkg::RATE_NUM / rr;
        return q[15:0];
    endfunction

    // Linear rate between anchor and beat, floored, clamped to 16 bits
    function automatic logic [15:0] interp_rate(input logic [31:0] g, input logic [31:0] t,
                                                input logic [15:0] yb);
        longint g_l, t_l, y_l, a_t, a_r, span, off, d, q;
        g_l = g;
        t_l = t;
        y_l = yb;
        a_t = anchor_ms;
        a_r = anchor_rate;
        span = t_l - a_t;
        off = g_l - a_t;
        if (g == t || span <= 0)
            return yb;
        d = (y_l - a_r) * off;
        q = d / span;
        if (d < 0 && (d % span) != 0)
            q = q - 1;
        q = q + a_r;
        if (q < 0)
            q = 0;
        if (q > 65535)
            q = 65535;
        return q[15:0];
    endfunction

    function automatic void add_sample(input logic [31:0] t, input logic [15:0] rate,
                                       input logic onb, input logic gap, input logic last);
        rrtr_pkg::t_result s;
        s.sample_time_ms = t;
        s.rate_q8 = rate;
        s.on_beat = onb;
        s.gap_restart = gap;
        s.last_of_run = last;
        pending_samples.insert(pending_samples.size(), s);
    endfunction

    // Work out the grid samples one accepted beat causes
    function automatic void predict_beat(input logic [15:0] rr, input logic opens);
        logic [31:0]     step;
        logic [31:0]     t;
        logic [31:0]     g;
        logic [31:0]     gk;
        logic [15:0]     yb;
        longint unsigned n;
        longint unsigned k;
        longint unsigned acc;
        step = (cfg_step == 10'd0) ? 32'd1 : {22'd0, cfg_step};
        if (opens) begin
            yb = beat_in_band(rr) ? beat_rate(rr) : cfg_fallback;
            beat_clock_ms = 32'd0;
            add_sample(32'd0, yb, 1'b1, 1'b0, 1'b1);
            anchor_ms = 32'd0;
            anchor_rate = yb;
            next_grid_ms = step;
            record_open = 1'b1;
            return;
        end
        if (!record_open) begin
            ignored_beats++;
            return;
        end
        acc = beat_clock_ms;
        acc = acc + rr;
        beat_clock_ms = (acc > CLOCK_MAX) ? CLOCK_MAX : acc[31:0];
        if (!beat_in_band(rr))
            return;
        t = beat_clock_ms;
        yb = beat_rate(rr);
        g = next_grid_ms;
        if (g <= t) begin
            n = (t - g) / step + 1;
            if (n > SPAN_LIMIT) begin
                // Too many points: one re-anchoring sample at the last grid point
                acc = g + (n - 1) * step;
                gk = acc[31:0];
                add_sample(gk, yb, gk == t, 1'b1, 1'b1);
            end else begin
                for (k = 0; k < n; k++) begin
                    acc = g + k * step;
                    gk = acc[31:0];
                    add_sample(gk, interp_rate(gk, t, yb), gk == t, 1'b0, k + 1 == n);
                end
            end
            acc = g + n * step;
            next_grid_ms = (acc > CLOCK_MAX) ? CLOCK_MAX : acc[31:0];
        end
        anchor_ms = t;
        anchor_rate = yb;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Compare each popped sample with the oldest expectation
    always @(posedge i_clk) begin
        rrtr_pkg::t_result want;
        if (i_rst_n && pop && !empty) begin
            if (pending_samples.size() == 0) begin
                $display("%0t: unexpected sample: expected none, actual time 0x%0h rate 0x%0h",
                         $time, o_sample_time_ms, o_rate_q8);
                mismatches++;
            end else begin
                want = pending_samples.pop_front();
                check_field("sample_time_ms", want.sample_time_ms, o_sample_time_ms);
                check_field("rate_q8", want.rate_q8, o_rate_q8);
                check_field("on_beat", want.on_beat, o_on_beat);
                check_field("gap_restart", want.gap_restart, o_gap_restart);
                check_field("last_of_run", want.last_of_run, o_last_of_run);
            end
            samples_checked++;
            if (o_gap_restart)
                restart_samples++;
        end
    end

    // End the run when no item moves for too long
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles, %0d samples still due",
                     $time, quiet_cycles, pending_samples.size());
            $display("rr_tachogram_resampler_top verification failed");
            $finish;
        end
    end

    // Sample sink: stalls in segments of random pop density, or holds off on request
    initial begin
        int seg_left;
        int pop_pct;
        seg_left = 0;
        pop_pct = 100;
        forever begin
            @(negedge i_clk);
            if (hold_rx_cycles > 0) begin
                hold_rx_cycles--;
                pop <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(16, 200);
                    case ($urandom_range(0, 3))
                        0: pop_pct = 100;
                        1: pop_pct = 85;
                        2: pop_pct = 50;
                        default: pop_pct = 15;
                    endcase
                end
                seg_left--;
                pop <= ($urandom_range(0, 99) < pop_pct);
            end
        end
    end

    // Offer one beat from a falling edge; leave push high on return
    task automatic send_beat(input logic [15:0] rr, input logic opens);
        push <= 1'b1;
        i_rr_ms <= rr;
        i_first_beat <= opens;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        predict_beat(rr, opens);
        beats_accepted++;
        @(negedge i_clk);
    endtask

    task automatic idle_sender(input int cycles);
        push <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // Hold the input until every expected sample is out
    task automatic drain_samples;
        push <= 1'b0;
        while (pending_samples.size() != 0)
            @(negedge i_clk);
    endtask

    // Drain, then allow time for beats that cause no sample to finish
    task automatic settle_block;
        drain_samples();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write one register, then read it back; the caller closes the transfer
    task automatic write_reg(input rrtr_pkg::t_reg_idx idx, input logic [31:0] value);
        logic [31:0] kept;
        case (idx)
            rrtr_pkg::REG_GRID_STEP: begin
                kept = {22'd0, value[9:0]};
                cfg_step = value[9:0];
            end
            rrtr_pkg::REG_MIN_BPM: begin
                kept = {24'd0, value[7:0]};
                cfg_min_bpm = value[7:0];
            end
            rrtr_pkg::REG_MAX_BPM: begin
                kept = {24'd0, value[7:0]};
                cfg_max_bpm = value[7:0];
            end
            default: begin
                kept = {16'd0, value[15:0]};
                cfg_fallback = value[15:0];
            end
        endcase
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        @(negedge i_clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (prdata !== kept) begin
            $display("%0t: register %s readback mismatch: expected 0x%0h, actual 0x%0h",
                     $time, idx.name(), kept, prdata);
            mismatches++;
        end
        @(negedge i_clk);
    endtask

    task automatic set_config(input int step, input int min_bpm, input int max_bpm,
                              input int fallback);
        settle_block();
        write_reg(rrtr_pkg::REG_GRID_STEP, step);
        write_reg(rrtr_pkg::REG_MIN_BPM, min_bpm);
        write_reg(rrtr_pkg::REG_MAX_BPM, max_bpm);
        write_reg(rrtr_pkg::REG_FALLBACK, fallback);
        psel <= 1'b0;
        penable <= 1'b0;
        settings_used++;
    endtask

    // Beats before any record must be dropped silently
    task automatic test_before_record;
        send_beat(16'd700, 1'b0);
        send_beat(16'd900, 1'b0);
    endtask

    // Reset settings: band edges, zero and huge RR, ordinary interpolation
    task automatic test_default_band;
        send_beat(16'd800, 1'b1);
        send_beat(16'd800, 1'b0);
        send_beat(16'd300, 1'b0);
        send_beat(16'd1500, 1'b0);
        send_beat(16'd1501, 1'b0);
        send_beat(16'd299, 1'b0);
        send_beat(16'd0, 1'b0);
        send_beat(16'd65535, 1'b0);
        send_beat(16'd1000, 1'b0);
    endtask

    // Out-of-band first beats take the fallback rate
    task automatic test_first_fallback;
        send_beat(16'd0, 1'b1);
        send_beat(16'd800, 1'b0);
        send_beat(16'd65535, 1'b1);
        send_beat(16'd900, 1'b0);
    endtask

    // Exactly the longest run, then spans that re-anchor on and off the beat
    task automatic test_long_span;
        set_config(10, 40, 200, 15360);
        send_beat(16'd640, 1'b1);
        send_beat(16'd640, 1'b0);
        send_beat(16'd650, 1'b0);
        send_beat(16'd655, 1'b0);
    endtask

    // Wide step: a kept beat with no grid point still moves the anchor
    task automatic test_wide_step;
        set_config(1000, 40, 200, 15360);
        send_beat(16'd400, 1'b1);
        send_beat(16'd400, 1'b0);
        send_beat(16'd400, 1'b0);
        send_beat(16'd1500, 1'b0);
    endtask

    // Zero step acts as one; widest band; zero fallback
    task automatic test_band_extremes;
        set_config(0, 1, 255, 0);
        send_beat(16'd65535, 1'b1);
        send_beat(16'd40000, 1'b0);
        send_beat(16'd236, 1'b1);
        send_beat(16'd236, 1'b0);
        send_beat(16'd235, 1'b0);
    endtask

    // Inverted band, then a zero upper bound: every later beat dropped
    task automatic test_empty_band;
        set_config(250, 255, 100, 65535);
        send_beat(16'd500, 1'b1);
        send_beat(16'd500, 1'b0);
        send_beat(16'd300, 1'b0);
        set_config(250, 40, 0, 65535);
        send_beat(16'd500, 1'b1);
        send_beat(16'd500, 1'b0);
    endtask

    // Sink holds off while beats keep coming, so both queues fill
    task automatic test_backpressure;
        set_config(250, 40, 200, 15360);
        hold_rx_cycles = HOLD_CYCLES;
        send_beat(16'd800, 1'b1);
        repeat (11) send_beat(16'($urandom_range(700, 1100)), 1'b0);
        drain_samples();
        send_beat(16'd750, 1'b0);
        send_beat(16'd820, 1'b0);
    endtask

    // Mostly well-formed records with random RR, plus noise, across several settings
    task automatic test_random_records;
        int unsigned lo_rr;
        int unsigned hi_rr;
        int          burst;
        int          left_in_record;
        int          sent;
        logic [15:0] rr;
        logic        opens;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: set_config($urandom_range(2, 20), $urandom_range(25, 60),
                              $urandom_range(150, 255), $urandom_range(0, 65535));
                1: set_config($urandom_range(100, 400), $urandom_range(25, 60),
                              $urandom_range(150, 255), $urandom_range(0, 65535));
                2: set_config(1, $urandom_range(1, 30), $urandom_range(200, 255),
                              $urandom_range(0, 65535));
                default: set_config($urandom_range(600, 1000), $urandom_range(25, 60),
                                    $urandom_range(150, 255), $urandom_range(0, 65535));
            endcase
            lo_rr = (rrtr_pkg::MS_PER_MIN + cfg_max_bpm - 1) / cfg_max_bpm;
            hi_rr = rrtr_pkg::MS_PER_MIN / cfg_min_bpm;
            left_in_record = 0;
            sent = 0;
            while (sent < RANDOM_PER_SETTING) begin
                burst = $urandom_range(1, 16);
                if (burst > RANDOM_PER_SETTING - sent)
                    burst = RANDOM_PER_SETTING - sent;
                repeat (burst) begin
                    if (left_in_record == 0) begin
                        opens = 1'b1;
                        left_in_record = $urandom_range(3, 20);
                        if ($urandom_range(0, 4) == 0)
                            rr = 16'($urandom_range(0, 65535));
                        else
                            rr = 16'($urandom_range(lo_rr, hi_rr));
                    end else begin
                        left_in_record--;
                        if ($urandom_range(0, 6) == 0) begin
                            rr = 16'($urandom_range(0, 65535));
                            opens = ($urandom_range(0, 15) == 0);
                        end else begin
                            rr = 16'($urandom_range(lo_rr, hi_rr));
                            opens = 1'b0;
                        end
                    end
                    send_beat(rr, opens);
                    sent++;
                end
                if ($urandom_range(0, 3) != 0)
                    idle_sender($urandom_range(1, ($urandom_range(0, 4) == 0) ? 400 : 40));
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        push = 1'b0;
        pop = 1'b0;
        i_rr_ms = 16'd0;
        i_first_beat = 1'b0;
        cfg_step = rrtr_pkg::GRID_STEP_RST;
        cfg_min_bpm = rrtr_pkg::MIN_BPM_RST;
        cfg_max_bpm = rrtr_pkg::MAX_BPM_RST;
        cfg_fallback = rrtr_pkg::FALLBACK_RST;
        beat_clock_ms = 32'd0;
        anchor_ms = 32'd0;
        anchor_rate = 16'd0;
        next_grid_ms = 32'd0;
        record_open = 1'b0;
        mismatches = 0;
        beats_accepted = 0;
        ignored_beats = 0;
        samples_checked = 0;
        restart_samples = 0;
        settings_used = 1;
        hold_rx_cycles = 0;
        quiet_cycles = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_before_record();
        test_default_band();
        test_first_fallback();
        test_long_span();
        test_wide_step();
        test_band_extremes();
        test_empty_band();
        test_backpressure();
        test_random_records();

        settle_block();
        $display("Summary: %0d beats accepted (%0d outside a record), %0d samples checked,",
                 beats_accepted, ignored_beats, samples_checked);
        $display("         %0d long-span restarts over %0d register settings",
                 restart_samples, settings_used);
        if (mismatches == 0)
            $display("rr_tachogram_resampler_top verification clean");
        else
            $display("rr_tachogram_resampler_top verification failed");
        $finish;
    end

endmodule
